[rtl/core/dtc_pkg.sv]
package dtc_pkg;

    // Default saturation width of the intermediate current values.
    localparam int DATA_WIDTH_DEF = 16;

    // Fixed port widths.
    localparam int IO_W  = 16;
    localparam int MAG_W = 15;

    // Q1.14 arithmetic.
    localparam int Q14_SHIFT      = 14;
    localparam int ROUND_Q14      = 8192;
    localparam int SQRT3_HALF_Q14 = 14189;

    // Zero zone of 5 A at 1/16 A per count.
    localparam int ZERO_ZONE      = 80;
    localparam int ZERO_ZONE_HALF = 40;

    // Floor division by 80 is an arithmetic shift by 4 and then a floor
    // division by 5. The divide by 5 works on a value offset to be positive,
    // below 2^21, using a reciprocal of 2^23 / 5 rounded up.
    localparam int DIV16_SHIFT  = 4;
    localparam int RECIP5       = 1677722;
    localparam int RECIP5_SHIFT = 23;
    localparam int DIV5_OFS_Q   = 262144;
    localparam int DIV5_OFS     = 5 * DIV5_OFS_Q;

    // Zone of one phase current.
    typedef struct packed {
        logic sat_pos;  // current at or above the zero zone
        logic sat_neg;  // current below the negative zero zone
    } t_zone;

endpackage

[rtl/core/deadtime_compensation_core.sv]
// Dead-time compensation core for a three-phase inverter.
//
// Input channel: i_valid / o_stall with the request fields i_id_ref, i_iq_ref,
// i_cos_theta and i_sin_theta. A request is taken at a rising edge with
// i_valid high and o_stall low. Output channel: o_valid / i_stall with the
// three phase compensation voltages o_comp_u, o_comp_v and o_comp_w.
// The magnitude register is written through i_cfg_valid / o_cfg_ready;
// o_cfg_ready is always high. Write it only while no request is in flight.
//
// The datapath is a seven-stage pipeline: the inverse Park products, the
// alpha/beta rounding, the sqrt(3)/2 product, the phase rounding, the
// linear-zone product, the reciprocal divide by five and the output register.
// A request moves through these stages in that order to the outputs, and a
// new request can be taken every cycle while o_stall is low.
// Each stage has its own valid bit and moves only when its successor is empty
// or moving, so bubbles close up while the receiver stalls; o_stall rises only
// once every stage holds a request. The stalled result holds still.
// The synchronous reset (i_rst_n low) empties the pipeline and clears the
// magnitude to zero.
module deadtime_compensation_core import dtc_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [MAG_W-1:0]        i_cfg_comp_magnitude,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [IO_W-1:0]  i_id_ref,
    input  logic signed [IO_W-1:0]  i_iq_ref,
    input  logic signed [IO_W-1:0]  i_cos_theta,
    input  logic signed [IO_W-1:0]  i_sin_theta,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [IO_W-1:0]  o_comp_u,
    output logic signed [IO_W-1:0]  o_comp_v,
    output logic signed [IO_W-1:0]  o_comp_w
);

    localparam int NSTG  = 7;
    localparam int PR_W  = 2 * IO_W;           // input product width
    localparam int AB_W  = PR_W + 2;           // alpha/beta sum width
    localparam int PB_W  = DATA_WIDTH + 16;    // sqrt(3)/2 * beta width
    localparam int SW    = DATA_WIDTH + 17;    // phase sum width
    localparam int MP_W  = MAG_W + 9;          // magnitude * current width
    localparam int NUM_W = MP_W + 1;
    localparam int U_W   = 21;                 // offset value for divide by 5
    localparam int RQ_W  = 2 * U_W;
    localparam int QH_W  = RQ_W - RECIP5_SHIFT;

    localparam logic signed [AB_W-1:0] AB_MAX =
        {{(AB_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [AB_W-1:0] AB_MIN =
        {{(AB_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [SW-1:0] SW_MAX =
        {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SW_MIN =
        {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [AB_W-1:0] AB_RND = AB_W'(ROUND_Q14);
    localparam logic signed [SW-1:0]   SW_RND = SW'(ROUND_Q14);
    localparam logic signed [15:0]     C_SQ3  = 16'(SQRT3_HALF_Q14);
    localparam logic signed [DATA_WIDTH-1:0] ZZ_POS = DATA_WIDTH'(ZERO_ZONE);
    localparam logic signed [DATA_WIDTH-1:0] ZZ_NEG = -ZZ_POS;
    localparam logic signed [NUM_W-1:0] NUM_RND = NUM_W'(ZERO_ZONE_HALF);
    localparam logic signed [NUM_W-1:0] NUM_OFS = NUM_W'(DIV5_OFS);
    localparam logic [U_W-1:0]  C_RECIP5 = U_W'(RECIP5);
    localparam logic [QH_W:0]   Q_OFS    = (QH_W+1)'(DIV5_OFS_Q);

    // ------------------------------------------------------------------
    // Configuration register. The write port never pushes back.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] r_mag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mag <= i_cfg_comp_magnitude;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. A stage loads when it is empty or its contents
    // move on in the same cycle.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the four inverse Park products.
    // ------------------------------------------------------------------
    logic signed [PR_W-1:0] r_p_idc, r_p_iqs, r_p_ids, r_p_iqc;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_p_idc <= i_id_ref * i_cos_theta;
            r_p_iqs <= i_iq_ref * i_sin_theta;
            r_p_ids <= i_id_ref * i_sin_theta;
            r_p_iqc <= i_iq_ref * i_cos_theta;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: alpha and beta, rounded half up and saturated.
    // ------------------------------------------------------------------
    logic signed [AB_W-1:0] n_sum_a, n_sum_b, n_rnd_a, n_rnd_b;
    logic signed [DATA_WIDTH-1:0] n_alpha, n_beta;
    logic signed [DATA_WIDTH-1:0] r_alpha2, r_beta2;

    always_comb begin
        n_sum_a = AB_W'(r_p_idc) - AB_W'(r_p_iqs) + AB_RND;
        n_sum_b = AB_W'(r_p_ids) + AB_W'(r_p_iqc) + AB_RND;
        n_rnd_a = n_sum_a >>> Q14_SHIFT;
        n_rnd_b = n_sum_b >>> Q14_SHIFT;
        if (n_rnd_a > AB_MAX) begin
            n_alpha = AB_MAX[DATA_WIDTH-1:0];
        end else if (n_rnd_a < AB_MIN) begin
            n_alpha = AB_MIN[DATA_WIDTH-1:0];
        end else begin
            n_alpha = n_rnd_a[DATA_WIDTH-1:0];
        end
        if (n_rnd_b > AB_MAX) begin
            n_beta = AB_MAX[DATA_WIDTH-1:0];
        end else if (n_rnd_b < AB_MIN) begin
            n_beta = AB_MIN[DATA_WIDTH-1:0];
        end else begin
            n_beta = n_rnd_b[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_alpha2 <= n_alpha;
            r_beta2  <= n_beta;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sqrt(3)/2 * beta. The half-alpha term is a plain shift.
    // ------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] r_alpha3;
    logic signed [PB_W-1:0]       r_pb;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_alpha3 <= r_alpha2;
            r_pb     <= r_beta2 * C_SQ3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: inverse Clarke. Phase a is alpha itself.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] n_half, n_pbw, n_sum_pb, n_sum_pc, n_rnd_pb, n_rnd_pc;
    logic signed [DATA_WIDTH-1:0] n_ib, n_ic;
    logic signed [DATA_WIDTH-1:0] r_i [3];

    always_comb begin
        n_half   = $signed({{4{r_alpha3[DATA_WIDTH-1]}}, r_alpha3, 13'b0});
        n_pbw    = $signed({{(SW-PB_W){r_pb[PB_W-1]}}, r_pb});
        n_sum_pb = n_pbw - n_half + SW_RND;
        n_sum_pc = -n_pbw - n_half + SW_RND;
        n_rnd_pb = n_sum_pb >>> Q14_SHIFT;
        n_rnd_pc = n_sum_pc >>> Q14_SHIFT;
        if (n_rnd_pb > SW_MAX) begin
            n_ib = SW_MAX[DATA_WIDTH-1:0];
        end else if (n_rnd_pb < SW_MIN) begin
            n_ib = SW_MIN[DATA_WIDTH-1:0];
        end else begin
            n_ib = n_rnd_pb[DATA_WIDTH-1:0];
        end
        if (n_rnd_pc > SW_MAX) begin
            n_ic = SW_MAX[DATA_WIDTH-1:0];
        end else if (n_rnd_pc < SW_MIN) begin
            n_ic = SW_MIN[DATA_WIDTH-1:0];
        end else begin
            n_ic = n_rnd_pc[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_i[0] <= r_alpha3;
            r_i[1] <= n_ib;
            r_i[2] <= n_ic;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: zone decision and the linear-zone product. Inside the
    // linear zone the current fits in eight signed bits.
    // ------------------------------------------------------------------
    t_zone                   r_zone5 [3];
    logic signed [MP_W-1:0]  r_mp    [3];

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int k = 0; k < 3; k++) begin
                r_zone5[k].sat_pos <= (r_i[k] >= ZZ_POS);
                r_zone5[k].sat_neg <= (r_i[k] < ZZ_NEG);
                r_mp[k] <= $signed({1'b0, r_mag}) * $signed(r_i[k][7:0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: floor((40 - M*I) / 80) as a shift by four and a reciprocal
    // multiply for the divide by five on an offset, positive value.
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] n_num [3];
    logic signed [NUM_W-1:0] n_ofs [3];
    logic [U_W-1:0]          n_u   [3];
    t_zone                   r_zone6 [3];
    logic [RQ_W-1:0]         r_rq    [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num[k] = NUM_RND - NUM_W'(r_mp[k]);
            n_ofs[k] = (n_num[k] >>> DIV16_SHIFT) + NUM_OFS;
            n_u[k]   = n_ofs[k][U_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int k = 0; k < 3; k++) begin
                r_zone6[k] <= r_zone5[k];
                r_rq[k]    <= n_u[k] * C_RECIP5;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: remove the offset and pick the zone result. Every choice
    // stays within the magnitude, so no further clipping is needed.
    // ------------------------------------------------------------------
    logic [QH_W:0]           n_qd [3];
    logic signed [IO_W-1:0]  n_comp [3];
    logic signed [IO_W-1:0]  r_comp [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_qd[k] = {1'b0, r_rq[k][RQ_W-1:RECIP5_SHIFT]} - Q_OFS;
            if (r_zone6[k].sat_pos) begin
                n_comp[k] = -$signed({1'b0, r_mag});
            end else if (r_zone6[k].sat_neg) begin
                n_comp[k] = $signed({1'b0, r_mag});
            end else begin
                n_comp[k] = $signed(n_qd[k][IO_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int k = 0; k < 3; k++) begin
                r_comp[k] <= n_comp[k];
            end
        end
    end

    assign o_comp_u = r_comp[0];
    assign o_comp_v = r_comp[1];
    assign o_comp_w = r_comp[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("pipeline not empty after reset");

    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted request did not enter the first stage");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld == {NSTG{1'b1}}) && i_stall)
        else $error("input stalled while the pipeline has room");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_comp_u != {1'b1, {(IO_W-1){1'b0}}})
                 && (o_comp_v != {1'b1, {(IO_W-1){1'b0}}})
                 && (o_comp_w != {1'b1, {(IO_W-1){1'b0}}}))
        else $error("compensation voltage out of range");

endmodule
